FILE: design/lpg_pkg.sv
package lpg_pkg;

  localparam int COORD_WIDTH = 10;
  localparam int COLOR_WIDTH = 16;
  // accumulator holds up to 2 * major_len before the subtract
  localparam int ERR_WIDTH   = COORD_WIDTH + 2;
  localparam int CNT_WIDTH   = COORD_WIDTH + 1;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [COLOR_WIDTH-1:0] color_t;
  typedef logic [ERR_WIDTH-1:0]   err_t;
  typedef logic [CNT_WIDTH-1:0]   cnt_t;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } dir_t;

  typedef struct packed {
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pixel_color;
  } in_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t out_color;
    logic   last;
  } out_word_t;

  typedef struct packed {
    logic   busy;
    coord_t cur_x;
    coord_t cur_y;
    err_t   err_x;
    err_t   err_y;
    coord_t abs_dx;
    coord_t abs_dy;
    coord_t major_len;
    dir_t   dir_x;
    dir_t   dir_y;
    cnt_t   points_left;
    color_t line_color;
  } line_state_t;

endpackage

FILE: design/lpg_in_if.sv
interface lpg_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  lpg_pkg::coord_t    start_x;
  lpg_pkg::coord_t    start_y;
  lpg_pkg::coord_t    end_x;
  lpg_pkg::coord_t    end_y;
  lpg_pkg::color_t    pixel_color;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, pixel_color,
                  input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, pixel_color,
                  output ready);
endinterface

FILE: design/lpg_out_if.sv
interface lpg_out_if;
  logic            valid;
  logic            ready;
  lpg_pkg::coord_t pixel_x;
  lpg_pkg::coord_t pixel_y;
  lpg_pkg::color_t out_color;
  logic            last;

  modport source (output valid, pixel_x, pixel_y, out_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, out_color, last, output ready);
endinterface

FILE: design/lpg_step.sv
module lpg_step (
  input  lpg_pkg::line_state_t cur_state,
  input  lpg_pkg::in_word_t    in_word,
  output lpg_pkg::line_state_t nxt_state,
  output logic                 has_result,
  output lpg_pkg::out_word_t   result
);

  lpg_pkg::err_t sum_x;
  lpg_pkg::err_t sum_y;
  lpg_pkg::err_t major_ext;
  logic          step_x;
  logic          step_y;
  lpg_pkg::coord_t dx;
  lpg_pkg::coord_t dy;

  always_comb begin
    nxt_state  = cur_state;
    has_result = 1'b0;
    major_ext  = {2'b00, cur_state.major_len};
    sum_x      = cur_state.err_x + {2'b00, cur_state.abs_dx};
    sum_y      = cur_state.err_y + {2'b00, cur_state.abs_dy};
    step_x     = sum_x > major_ext;
    step_y     = sum_y > major_ext;
    dx         = '0;
    dy         = '0;

    if (in_word.kind == lpg_pkg::KIND_START) begin
      has_result = 1'b1;
      if (in_word.end_x > in_word.start_x) begin
        dx                = in_word.end_x - in_word.start_x;
        nxt_state.dir_x   = lpg_pkg::DIR_POS;
      end else if (in_word.end_x == in_word.start_x) begin
        nxt_state.dir_x   = lpg_pkg::DIR_NONE;
      end else begin
        dx                = in_word.start_x - in_word.end_x;
        nxt_state.dir_x   = lpg_pkg::DIR_NEG;
      end
      if (in_word.end_y > in_word.start_y) begin
        dy                = in_word.end_y - in_word.start_y;
        nxt_state.dir_y   = lpg_pkg::DIR_POS;
      end else if (in_word.end_y == in_word.start_y) begin
        nxt_state.dir_y   = lpg_pkg::DIR_NONE;
      end else begin
        dy                = in_word.start_y - in_word.end_y;
        nxt_state.dir_y   = lpg_pkg::DIR_NEG;
      end
      nxt_state.abs_dx      = dx;
      nxt_state.abs_dy      = dy;
      nxt_state.major_len   = (dx > dy) ? dx : dy;
      nxt_state.cur_x       = in_word.start_x;
      nxt_state.cur_y       = in_word.start_y;
      nxt_state.err_x       = '0;
      nxt_state.err_y       = '0;
      nxt_state.line_color  = in_word.pixel_color;
      nxt_state.points_left = {1'b0, nxt_state.major_len};
      nxt_state.busy        = (nxt_state.major_len != '0);
    end else if (cur_state.busy) begin
      has_result = 1'b1;
      nxt_state.err_x = step_x ? (sum_x - major_ext) : sum_x;
      nxt_state.err_y = step_y ? (sum_y - major_ext) : sum_y;
      if (step_x) begin
        case (cur_state.dir_x)
          lpg_pkg::DIR_POS: nxt_state.cur_x = cur_state.cur_x + 1'b1;
          lpg_pkg::DIR_NEG: nxt_state.cur_x = cur_state.cur_x - 1'b1;
          default:          nxt_state.cur_x = cur_state.cur_x;
        endcase
      end
      if (step_y) begin
        case (cur_state.dir_y)
          lpg_pkg::DIR_POS: nxt_state.cur_y = cur_state.cur_y + 1'b1;
          lpg_pkg::DIR_NEG: nxt_state.cur_y = cur_state.cur_y - 1'b1;
          default:          nxt_state.cur_y = cur_state.cur_y;
        endcase
      end
      nxt_state.points_left = cur_state.points_left - 1'b1;
      nxt_state.busy        = (nxt_state.points_left != '0);
    end

    result.pixel_x   = nxt_state.cur_x;
    result.pixel_y   = nxt_state.cur_y;
    result.out_color = nxt_state.line_color;
    result.last      = (nxt_state.points_left == '0);
  end

endmodule

FILE: design/lpg_out_buf.sv
module lpg_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpg_pkg::out_word_t push_word,
  output logic               space,
  lpg_out_if.source          out_ch
);

  lpg_pkg::out_word_t entry_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic [1:0]         count_nxt;
  logic               pop;

  assign space = (count_r != 2'd2);
  assign pop   = out_ch.valid && out_ch.ready;

  assign out_ch.valid     = (count_r != 2'd0);
  assign out_ch.pixel_x   = entry_r[rd_ptr_r].pixel_x;
  assign out_ch.pixel_y   = entry_r[rd_ptr_r].pixel_y;
  assign out_ch.out_color = entry_r[rd_ptr_r].out_color;
  assign out_ch.last      = entry_r[rd_ptr_r].last;

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_word;
  end

endmodule

FILE: design/line_pixel_generator.sv
// Line pixel generator: turns a start word (two endpoints and an RGB565 colour)
// into the pixels of a straight line, one pixel per following advance word,
// using Bresenham-style error accumulators on both axes. A start word emits
// the first endpoint at once; a line of major length N yields N+1 pixels and
// the final one carries last. A start word while a line is running drops that
// line and begins the new one; an advance word with no line running is taken
// and gives no pixel. One word is accepted every clock while the buffer has
// space: all the stepping is a single add, compare and subtract per axis
// between the line state register and a two-entry result buffer, and each
// pixel is registered in that buffer and offered on out_ch from there.
// in_ch.ready depends only on that buffer and falls only when both entries hold pixels the sink has not taken yet.
module line_pixel_generator (
  input  logic      clk,
  input  logic      rst_n,
  lpg_in_if.sink    in_ch,
  lpg_out_if.source out_ch
);

  lpg_pkg::line_state_t state_r;
  lpg_pkg::line_state_t state_nxt;
  lpg_pkg::in_word_t    in_word;
  lpg_pkg::out_word_t   result;
  logic                 has_result;
  logic                 buf_space;
  logic                 accept;

  // gather the input channel into one word
  assign in_word.kind        = in_ch.kind;
  assign in_word.start_x     = in_ch.start_x;
  assign in_word.start_y     = in_ch.start_y;
  assign in_word.end_x       = in_ch.end_x;
  assign in_word.end_y       = in_ch.end_y;
  assign in_word.pixel_color = in_ch.pixel_color;

  // ready comes from buffer occupancy only, never from out_ch.ready
  assign in_ch.ready = buf_space;
  assign accept      = in_ch.valid && buf_space;

  lpg_step u_step (
    .cur_state  (state_r),
    .in_word    (in_word),
    .nxt_state  (state_nxt),
    .has_result (has_result),
    .result     (result)
  );

  // line state only moves on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  lpg_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && has_result),
    .push_word (result),
    .space     (buf_space),
    .out_ch    (out_ch)
  );

endmodule

FILE: design/lpg_checker.sv
module lpg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_kind,
  input lpg_pkg::coord_t in_start_x,
  input lpg_pkg::coord_t in_start_y,
  input lpg_pkg::coord_t in_end_x,
  input lpg_pkg::coord_t in_end_y,
  input lpg_pkg::color_t in_pixel_color,
  input logic            out_valid,
  input logic            out_ready,
  input lpg_pkg::coord_t out_pixel_x,
  input lpg_pkg::coord_t out_pixel_y,
  input lpg_pkg::color_t out_out_color,
  input logic            out_last
);

  logic start_into_empty;
  assign start_into_empty = in_valid && in_ready && !out_valid &&
                            (in_kind == lpg_pkg::KIND_START);

  // a pending pixel is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel dropped before it was taken");

  // empty buffer must never stall the source
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result buffer");

  // start into an empty buffer shows its first endpoint next cycle
  a_start_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start_into_empty |=> out_valid && out_pixel_x == $past(in_start_x) &&
                         out_pixel_y == $past(in_start_y) &&
                         out_out_color == $past(in_pixel_color))
    else $error("first pixel of line wrong");

  // single-point line ends at once
  a_single_point_last: assert property (@(posedge clk) disable iff (!rst_n)
    start_into_empty && in_start_x == in_end_x && in_start_y == in_end_y
    |=> out_last)
    else $error("single-point line not flagged last");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_kind        (in_ch.kind),
  .in_start_x     (in_ch.start_x),
  .in_start_y     (in_ch.start_y),
  .in_end_x       (in_ch.end_x),
  .in_end_y       (in_ch.end_y),
  .in_pixel_color (in_ch.pixel_color),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pixel_x    (out_ch.pixel_x),
  .out_pixel_y    (out_ch.pixel_y),
  .out_out_color  (out_ch.out_color),
  .out_last       (out_ch.last)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_MAX = (1 << lpg_pkg::COORD_WIDTH) - 1;
  localparam int COLOR_MAX = (1 << lpg_pkg::COLOR_WIDTH) - 1;

  logic clk = 1'b0;
  logic rst_n;

  lpg_in_if  in_ch();
  lpg_out_if out_ch();

  line_pixel_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Random gaps on the sending side and stalls on the receiving side;
  // cleared together for the full-rate stretch.
  bit in_gaps_on    = 1'b1;
  bit out_stalls_on = 1'b1;

  int mismatches;
  int words_sent;
  int lines_drawn;
  int pixels_predicted;
  int pixels_checked;

  // Pixels worked out by the line tracer, oldest first.
  lpg_pkg::out_word_t pending_pixels[$];

  // Line tracer state: mirrors the block's own registers.
  logic            tr_busy;
  lpg_pkg::coord_t tr_x, tr_y;
  lpg_pkg::err_t   tr_err_x, tr_err_y;
  lpg_pkg::coord_t tr_dx, tr_dy;
  lpg_pkg::coord_t tr_major;
  lpg_pkg::dir_t   tr_dir_x, tr_dir_y;
  lpg_pkg::cnt_t   tr_left;
  lpg_pkg::color_t tr_color;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Absolute delta and step direction for one axis.
  task automatic axis_span(input lpg_pkg::coord_t from, input lpg_pkg::coord_t to,
                           output lpg_pkg::coord_t mag, output lpg_pkg::dir_t dir);
    if (to > from) begin
      mag = to - from;
      dir = lpg_pkg::DIR_POS;
    end else if (to == from) begin
      mag = '0;
      dir = lpg_pkg::DIR_NONE;
    end else begin
      mag = from - to;
      dir = lpg_pkg::DIR_NEG;
    end
  endtask

  function automatic lpg_pkg::coord_t step_coord(input lpg_pkg::coord_t pos,
                                                 input lpg_pkg::dir_t dir);
    case (dir)
      lpg_pkg::DIR_POS: return pos + 1'b1;
      lpg_pkg::DIR_NEG: return pos - 1'b1;
      default:          return pos;
    endcase
  endfunction

  // Works out the pixel (if any) caused by one accepted word and queues it.
  task automatic trace_pixel(input lpg_pkg::in_word_t w);
    lpg_pkg::out_word_t px;
    if (w.kind == lpg_pkg::KIND_START) begin
      axis_span(w.start_x, w.end_x, tr_dx, tr_dir_x);
      axis_span(w.start_y, w.end_y, tr_dy, tr_dir_y);
      tr_major = (tr_dx > tr_dy) ? tr_dx : tr_dy;
      tr_x     = w.start_x;
      tr_y     = w.start_y;
      tr_err_x = '0;
      tr_err_y = '0;
      tr_color = w.pixel_color;
      tr_left  = {1'b0, tr_major};
      tr_busy  = (tr_left != '0);
      lines_drawn++;
    end else begin
      // advance with no line running is swallowed
      if (!tr_busy) return;
      tr_err_x = tr_err_x + {2'b00, tr_dx};
      tr_err_y = tr_err_y + {2'b00, tr_dy};
      if (tr_err_x > {2'b00, tr_major}) begin
        tr_err_x = tr_err_x - {2'b00, tr_major};
        tr_x     = step_coord(tr_x, tr_dir_x);
      end
      if (tr_err_y > {2'b00, tr_major}) begin
        tr_err_y = tr_err_y - {2'b00, tr_major};
        tr_y     = step_coord(tr_y, tr_dir_y);
      end
      tr_left = tr_left - 1'b1;
      tr_busy = (tr_left != '0);
    end
    px.pixel_x   = tr_x;
    px.pixel_y   = tr_y;
    px.out_color = tr_color;
    px.last      = (tr_left == '0);
    pending_pixels.push_back(px);
    pixels_predicted++;
  endtask

  // Offers one word and waits for the handshake. Valid is left high so that
  // back-to-back words never drop it within a time step.
  task automatic send_word(input lpg_pkg::in_word_t w);
    while (in_gaps_on && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= w.kind;
    in_ch.start_x     <= w.start_x;
    in_ch.start_y     <= w.start_y;
    in_ch.end_x       <= w.end_x;
    in_ch.end_y       <= w.end_y;
    in_ch.pixel_color <= w.pixel_color;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    trace_pixel(w);
  endtask

  // Random content in every field; unused fields still toggle on advance.
  function automatic lpg_pkg::in_word_t random_word(input lpg_pkg::kind_t k);
    lpg_pkg::in_word_t w;
    w.kind        = k;
    w.start_x     = lpg_pkg::coord_t'($urandom_range(COORD_MAX));
    w.start_y     = lpg_pkg::coord_t'($urandom_range(COORD_MAX));
    w.end_x       = lpg_pkg::coord_t'($urandom_range(COORD_MAX));
    w.end_y       = lpg_pkg::coord_t'($urandom_range(COORD_MAX));
    w.pixel_color = lpg_pkg::color_t'($urandom_range(COLOR_MAX));
    return w;
  endfunction

  task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                            input int col);
    lpg_pkg::in_word_t w;
    w             = random_word(lpg_pkg::KIND_START);
    w.start_x     = lpg_pkg::coord_t'(sx);
    w.start_y     = lpg_pkg::coord_t'(sy);
    w.end_x       = lpg_pkg::coord_t'(ex);
    w.end_y       = lpg_pkg::coord_t'(ey);
    w.pixel_color = lpg_pkg::color_t'(col);
    send_word(w);
  endtask

  task automatic advance(input int n);
    repeat (n) send_word(random_word(lpg_pkg::KIND_ADVANCE));
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls on ready, and every taken word is checked
  // against the oldest traced pixel. Sampled at the edge, before any
  // register of the block moves.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                  out_ch.pixel_x, out_ch.pixel_y));
      end else begin
        lpg_pkg::out_word_t exp_px;
        exp_px = pending_pixels.pop_front();
        pixels_checked++;
        if (out_ch.pixel_x !== exp_px.pixel_x)
          report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                    out_ch.pixel_x, exp_px.pixel_x));
        if (out_ch.pixel_y !== exp_px.pixel_y)
          report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                    out_ch.pixel_y, exp_px.pixel_y));
        if (out_ch.out_color !== exp_px.out_color)
          report_mismatch($sformatf("out_color %h, expected %h",
                                    out_ch.out_color, exp_px.out_color));
        if (out_ch.last !== exp_px.last)
          report_mismatch($sformatf("last %b, expected %b",
                                    out_ch.last, exp_px.last));
      end
    end
    out_ch.ready <= !(out_stalls_on && $urandom_range(99) < 30);
  end

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // advance straight after reset: nothing running, so no pixel
  task automatic test_idle_advance();
    advance(1);
  endtask

  // both endpoints equal: one pixel flagged last, then idle again
  task automatic test_single_points();
    start_line(0, 0, 0, 0, 16'h0000);
    advance(1);
    start_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
  endtask

  // shallow and vertical lines, at both coordinate extremes
  task automatic test_short_lines();
    start_line(0, 0, 3, 1, 16'hF800);
    advance(3);
    start_line(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 1, 16'h07E0);
    advance(3);
    start_line(5, 0, 5, 2, 16'h001F);
    advance(2);
  endtask

  // start while a line is still running: the old one is dropped
  task automatic test_restart();
    start_line(0, COORD_MAX, 4, COORD_MAX - 4, 16'hAAAA);
    advance(1);
    start_line(2, 2, 0, 2, 16'h5555);
    advance(2);
  endtask

  // one line across the whole panel, both axes stepping backwards/forwards
  task automatic test_long_line();
    start_line(COORD_MAX, 17, 0, 1000, 16'h1234);
    advance(COORD_MAX);
  endtask

  // Mostly well-formed lines with random endpoints near each other, a few
  // longer ones, some cut short by a new start, some with surplus advances,
  // and a sprinkle of lone advance words.
  task automatic test_random_lines(input int budget);
    int first_px;
    int roll, sx, sy, ex, ey, lo_x, hi_x, lo_y, hi_y, n, span;
    first_px = pixels_predicted;
    while (pixels_predicted - first_px < budget) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        advance(1);
      end else begin
        sx   = $urandom_range(COORD_MAX);
        sy   = $urandom_range(COORD_MAX);
        span = (roll < 8) ? 128 : 16;
        lo_x = (sx > span) ? sx - span : 0;
        hi_x = (sx + span < COORD_MAX) ? sx + span : COORD_MAX;
        lo_y = (sy > span) ? sy - span : 0;
        hi_y = (sy + span < COORD_MAX) ? sy + span : COORD_MAX;
        ex   = $urandom_range(hi_x, lo_x);
        ey   = $urandom_range(hi_y, lo_y);
        start_line(sx, sy, ex, ey, $urandom_range(COLOR_MAX));
        n = int'(tr_left);
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        else if ($urandom_range(9) == 0) n = n + $urandom_range(2, 1);
        advance(n);
      end
    end
  endtask

  // no gaps and no stalls at all for a while
  task automatic test_full_rate();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    test_random_lines(150);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // wait for every traced pixel, then keep watching the output for strays
  task automatic drain();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    while (pending_pixels.size() != 0) begin
      lpg_pkg::out_word_t lost;
      lost = pending_pixels.pop_front();
      report_mismatch($sformatf("pixel (%0d,%0d) never came", lost.pixel_x, lost.pixel_y));
    end
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= lpg_pkg::KIND_START;
    in_ch.start_x     <= '0;
    in_ch.start_y     <= '0;
    in_ch.end_x       <= '0;
    in_ch.end_y       <= '0;
    in_ch.pixel_color <= '0;
    tr_busy  = 1'b0;
    tr_x     = '0;
    tr_y     = '0;
    tr_err_x = '0;
    tr_err_y = '0;
    tr_dx    = '0;
    tr_dy    = '0;
    tr_major = '0;
    tr_dir_x = lpg_pkg::DIR_NONE;
    tr_dir_y = lpg_pkg::DIR_NONE;
    tr_left  = '0;
    tr_color = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_advance();
    test_single_points();
    test_short_lines();
    test_restart();
    test_long_line();
    test_random_lines(250);
    test_full_rate();
    drain();

    $display("summary: %0d words sent, %0d lines started, %0d pixels checked, %0d mismatches",
             words_sent, lines_drawn, pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well beyond the slowest legitimate run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
design/lpg_pkg.sv
design/lpg_in_if.sv
design/lpg_out_if.sv
design/lpg_step.sv
design/lpg_out_buf.sv
design/line_pixel_generator.sv
design/lpg_checker.sv
tb/tb_top.sv
